// ===== sv/fad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fad_pkg
// shared types and constants for the float absolute difference block
// ----------------------------------------------------------------------------
package fad_pkg;

  localparam logic [31:0] MAG_MASK    = 32'h7FFF_FFFF;
  localparam logic [30:0] DEFAULT_NAN = 31'h7FC0_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;
  localparam logic [22:0] QUIET_BIT   = 23'h40_0000;

  typedef struct packed {
    logic        special;
    logic [30:0] special_mag;
    logic        eff_sub;
    logic [7:0]  big_exp;
    logic [23:0] big_man;
    logic [7:0]  shift;
    logic [23:0] small_man;
  } fad_align_t;

endpackage : fad_pkg
`default_nettype wire

// ===== sv/fad_align.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fad_align
// operand classification, special cases and magnitude ordering
// ----------------------------------------------------------------------------
module fad_align (
  input  wire logic [31:0]          a,
  input  wire logic [31:0]          b,
  output fad_pkg::fad_align_t       info
);
  import fad_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [7:0]  ea, eb, eae, ebe;
  logic [23:0] ma, mb;
  logic        sb;

  always_comb begin
    ea    = a[30:23];
    eb    = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:0] == INF_MAG);
    b_inf = (b[30:0] == INF_MAG);
    sb    = ~b[31];
    // subnormals use exponent one with no hidden bit
    eae   = (ea == 8'd0) ? 8'd1 : ea;
    ebe   = (eb == 8'd0) ? 8'd1 : eb;
    ma    = {(ea != 8'd0), a[22:0]};
    mb    = {(eb != 8'd0), b[22:0]};
    swap  = (b[30:0] > a[30:0]);

    info.eff_sub     = a[31] ^ sb;
    info.special     = 1'b1;
    info.special_mag = INF_MAG;
    if (a_nan) begin
      info.special_mag = a[30:0] | {8'd0, QUIET_BIT};
    end else if (b_nan) begin
      info.special_mag = b[30:0] | {8'd0, QUIET_BIT};
    end else if (a_inf && b_inf && (a == b)) begin
      info.special_mag = DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      info.special_mag = INF_MAG;
    end else begin
      info.special = 1'b0;
    end

    if (swap) begin
      info.big_exp   = ebe;
      info.big_man   = mb;
      info.small_man = ma;
      info.shift     = ebe - eae;
    end else begin
      info.big_exp   = eae;
      info.big_man   = ma;
      info.small_man = mb;
      info.shift     = eae - ebe;
    end
  end

endmodule : fad_align
`default_nettype wire

// ===== sv/fad_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fad_round
// aligned add or subtract, normalisation and round to nearest even
// ----------------------------------------------------------------------------
module fad_round (
  input  wire fad_pkg::fad_align_t info,
  output logic [30:0]              mag
);
  import fad_pkg::*;

  logic [26:0] big_x, small_x, sh_x;
  logic [27:0] sum;
  logic [4:0]  lz;
  logic        found;
  logic [9:0]  exp_w;
  logic [27:0] norm;
  logic [23:0] man;
  logic [24:0] man_r;
  logic        sticky, rnd_up;
  logic [9:0]  exp_f;
  logic [4:0]  lsh;

  always_comb begin
    big_x   = {info.big_man, 3'b000};
    small_x = {info.small_man, 3'b000};
    sticky  = 1'b0;
    lsh     = 5'd0;
    // guard, round, sticky alignment
    if (info.shift >= 8'd27) begin
      sh_x = {26'd0, (info.small_man != 24'd0)};
    end else begin
      sh_x = small_x >> info.shift[4:0];
      for (int i = 0; i < 27; i++) begin
        if ((i < int'(info.shift)) && small_x[i]) sticky = 1'b1;
      end
      sh_x[0] = sh_x[0] | sticky;
    end
    sum = info.eff_sub ? ({1'b0, big_x} - {1'b0, sh_x}) : ({1'b0, big_x} + {1'b0, sh_x});

    lz    = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && sum[i]) begin
        found = 1'b1;
        lz    = 5'(26 - i);
      end
    end

    exp_w = {2'b00, info.big_exp};
    if (sum[27]) begin
      norm  = {1'b0, sum[27:2], sum[1] | sum[0]};
      exp_w = exp_w + 10'd1;
    end else begin
      // left shift limited so the exponent stays at one (subnormal)
      lsh = (10'(lz) < exp_w) ? lz : 5'(exp_w - 10'd1);
      norm  = sum << lsh;
      exp_w = exp_w - 10'(lsh);
    end
    man    = norm[26:3];
    rnd_up = norm[2] && (norm[1] || norm[0] || man[0]);
    man_r  = {1'b0, man} + 25'(rnd_up);
    exp_f  = exp_w;
    if (man_r[24]) begin
      exp_f = exp_f + 10'd1;
    end else if (!man_r[23]) begin
      exp_f = 10'd0;
    end

    if (info.special) begin
      mag = info.special_mag;
    end else if (sum == 28'd0) begin
      mag = 31'd0;
    end else if (exp_f >= 10'd255) begin
      mag = INF_MAG;
    end else if (man_r[24]) begin
      mag = {exp_f[7:0], man_r[23:1]};
    end else begin
      mag = {exp_f[7:0], man_r[22:0]};
    end
  end

endmodule : fad_round
`default_nettype wire

// ===== sv/float_absolute_difference.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_absolute_difference
// magnitude of a rounded single-precision subtraction
// ----------------------------------------------------------------------------
// Takes one operand pair per cycle (busy is always low). Operands are captured
// in an input register, classified, aligned, subtracted and rounded in one
// combinational pass; the result is registered onto difference_magnitude_bits
// and done is registered alongside it. Results cannot be stalled.
module float_absolute_difference (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] minuend_bits,
  input  wire logic [31:0] subtrahend_bits,
  output logic             done,
  output logic [30:0]      difference_magnitude_bits
);
  import fad_pkg::*;

  logic [31:0] a, b;
  logic        a_valid;
  fad_align_t  info;
  logic [30:0] mag;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= start;
      done    <= a_valid;
    end
    a <= minuend_bits;
    b <= subtrahend_bits;
    difference_magnitude_bits <= mag;
  end

  fad_align u_align (.a(a), .b(b), .info(info));
  fad_round u_round (.info(info), .mag(mag));

  a_done_follows : assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done) else $error("done did not follow start");
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2)) else $error("done without start");
  a_never_busy : assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule : float_absolute_difference
`default_nettype wire
